// File: hw/rtl/hbtm_pkg.sv
// Shared constants and types for the best-two Hamming matcher.
package hbtm_pkg;

  localparam int unsigned DescBits  = 256;
  localparam int unsigned WordBits  = 64;
  localparam int unsigned NumWords  = DescBits / WordBits;
  localparam int unsigned WordCntW  = $clog2(WordBits + 1);
  localparam int unsigned DistW     = $clog2(DescBits + 1);
  localparam int unsigned IndexW    = 16;
  localparam int unsigned PosW      = IndexW + 1;
  localparam int unsigned CfgIndexW = $clog2(NumWords);

  localparam logic [DistW-1:0] DistNone = DistW'(DescBits);
  localparam logic [PosW-1:0]  PosNone  = {PosW{1'b1}};

  localparam logic [WordBits-1:0] PairMask   = 64'h5555_5555_5555_5555;
  localparam logic [WordBits-1:0] NibbleMask = 64'h3333_3333_3333_3333;
  localparam logic [WordBits-1:0] ByteMask   = 64'h0F0F_0F0F_0F0F_0F0F;

  // One registered descriptor: flags, index and per-word bit counts.
  typedef struct packed {
    logic                              first;
    logic                              last;
    logic [IndexW-1:0]                 index;
    logic [NumWords-1:0][WordCntW-1:0] word_count;
  } hbtm_item_t;

endpackage

// File: hw/rtl/hbtm_popcount.sv
// Population count of one 64-bit word, SWAR style.
module hbtm_popcount (
  input  logic [hbtm_pkg::WordBits-1:0] word,
  output logic [hbtm_pkg::WordCntW-1:0] count
);
  import hbtm_pkg::*;

  logic [WordBits-1:0] pairs;
  logic [WordBits-1:0] nibbles;
  logic [WordBits-1:0] bytes_sum;

  assign pairs     = word - ((word >> 1) & PairMask);
  assign nibbles   = (pairs & NibbleMask) + ((pairs >> 2) & NibbleMask);
  assign bytes_sum = (nibbles + (nibbles >> 4)) & ByteMask;

  // Add the eight byte lanes; each lane holds at most 8.
  always_comb begin
    logic [WordCntW-1:0] acc;
    acc = '0;
    for (int i = 0; i < WordBits / 8; i++) begin
      acc = acc + WordCntW'(bytes_sum[8*i +: 4]);
    end
    count = acc;
  end

endmodule

// File: hw/rtl/hbtm_tracker.sv
// Running best/second-best tracker and result register.
module hbtm_tracker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  input  hbtm_pkg::hbtm_item_t          item,
  output logic                          advance,
  output logic                          match_valid,
  input  logic                          match_stall,
  output logic [hbtm_pkg::DistW-1:0]    best_distance,
  output logic signed [hbtm_pkg::PosW-1:0] best_position,
  output logic [hbtm_pkg::DistW-1:0]    second_distance
);
  import hbtm_pkg::*;

  logic [DistW-1:0] best_dist;
  logic [DistW-1:0] second_dist;
  logic [PosW-1:0]  best_idx;

  logic [DistW-1:0] distance;
  logic [DistW-1:0] cur_best;
  logic [DistW-1:0] cur_second;
  logic [PosW-1:0]  cur_idx;
  logic [DistW-1:0] best_dist_next;
  logic [DistW-1:0] second_dist_next;
  logic [PosW-1:0]  best_idx_next;
  logic             can_load;
  logic             fire;

  always_comb begin
    distance = '0;
    for (int w = 0; w < NumWords; w++) begin
      distance = distance + DistW'(item.word_count[w]);
    end
  end

  assign cur_best   = item.first ? DistNone : best_dist;
  assign cur_second = item.first ? DistNone : second_dist;
  assign cur_idx    = item.first ? PosNone  : best_idx;

  always_comb begin
    best_dist_next   = cur_best;
    second_dist_next = cur_second;
    best_idx_next    = cur_idx;
    priority if (distance < cur_best) begin
      second_dist_next = cur_best;
      best_dist_next   = distance;
      best_idx_next    = {1'b0, item.index};
    end else if (distance < cur_second) begin
      second_dist_next = distance;
    end
  end

  // A last word needs a free result register; other words never wait.
  assign can_load = !match_valid || !match_stall;
  assign advance  = !item_valid || !item.last || can_load;
  assign fire     = item_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      best_dist   <= DistNone;
      second_dist <= DistNone;
      best_idx    <= PosNone;
      match_valid <= 1'b0;
    end else begin
      if (fire) begin
        best_dist   <= best_dist_next;
        second_dist <= second_dist_next;
        best_idx    <= best_idx_next;
      end
      if (fire && item.last) begin
        match_valid <= 1'b1;
      end else if (!match_stall) begin
        match_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && item.last) begin
      best_distance   <= best_dist_next;
      best_position   <= signed'(best_idx_next);
      second_distance <= second_dist_next;
    end
  end

endmodule

// File: hw/rtl/hamming_best_two_matcher_top.sv
// Top level of the best-two Hamming matcher.
//
//   channel  direction  handshake               payload
//   train    in         train_valid/train_stall first, last, train_index, train_word0..3
//   match    out        match_valid/match_stall best_distance, best_position, second_distance
//   cfg      in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
// One descriptor word per cycle unless stalled; each result is registered in stage 2.
// Stage 1 registers each 64-bit word's bit count; stage 2 sums, compares and updates.
// Reset clears the query to zero and the running values to 256, -1, 256.
// A stalled result blocks only a following last word; other words keep flowing.
// cfg_ready is always high.
module hamming_best_two_matcher_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              train_valid,
  output logic                              train_stall,
  input  logic                              first,
  input  logic                              last,
  input  logic [hbtm_pkg::IndexW-1:0]       train_index,
  input  logic [hbtm_pkg::WordBits-1:0]     train_word0,
  input  logic [hbtm_pkg::WordBits-1:0]     train_word1,
  input  logic [hbtm_pkg::WordBits-1:0]     train_word2,
  input  logic [hbtm_pkg::WordBits-1:0]     train_word3,
  output logic                              match_valid,
  input  logic                              match_stall,
  output logic [hbtm_pkg::DistW-1:0]        best_distance,
  output logic signed [hbtm_pkg::PosW-1:0]  best_position,
  output logic [hbtm_pkg::DistW-1:0]        second_distance,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hbtm_pkg::CfgIndexW-1:0]    cfg_index,
  input  logic [hbtm_pkg::WordBits-1:0]     cfg_data
);
  import hbtm_pkg::*;

  logic [NumWords-1:0][WordBits-1:0] query;
  logic [NumWords-1:0][WordBits-1:0] train;
  logic [NumWords-1:0][WordCntW-1:0] count;
  hbtm_item_t                        stage;
  logic                              stage_valid;
  logic                              advance;
  logic                              load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      query <= '0;
    end else if (cfg_valid && cfg_ready) begin
      query[cfg_index] <= cfg_data;
    end
  end

  assign train = {train_word3, train_word2, train_word1, train_word0};

  for (genvar w = 0; w < NumWords; w++) begin : g_count
    hbtm_popcount u_popcount (
      .word  (query[w] ^ train[w]),
      .count (count[w])
    );
  end

  assign train_stall = stage_valid && !advance;
  assign load        = train_valid && !train_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!stage_valid || advance) begin
      stage_valid <= train_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage.first      <= first;
      stage.last       <= last;
      stage.index      <= train_index;
      stage.word_count <= count;
    end
  end

  hbtm_tracker u_tracker (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (stage_valid),
    .item            (stage),
    .advance         (advance),
    .match_valid     (match_valid),
    .match_stall     (match_stall),
    .best_distance   (best_distance),
    .best_position   (best_position),
    .second_distance (second_distance)
  );

endmodule

// File: hw/rtl/hbtm_checker.sv
// Port-level checks for the best-two Hamming matcher, bound to the top level.
module hbtm_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              match_valid,
  input logic                              match_stall,
  input logic [hbtm_pkg::DistW-1:0]        best_distance,
  input logic signed [hbtm_pkg::PosW-1:0]  best_position,
  input logic [hbtm_pkg::DistW-1:0]        second_distance
);
  import hbtm_pkg::*;

  // Hold a stalled result word.
  a_match_hold: assert property (@(posedge clk) disable iff (rst)
    match_valid && match_stall |=> match_valid && $stable(best_distance)
      && $stable(best_position) && $stable(second_distance))
    else $error("stalled match word changed");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !match_valid)
    else $error("match word right after reset");

  a_order: assert property (@(posedge clk) disable iff (rst)
    match_valid |-> second_distance >= best_distance && best_distance <= DistNone)
    else $error("second distance below best");

  // A missing best index goes with a best distance of 256, and only with it.
  a_none: assert property (@(posedge clk) disable iff (rst)
    match_valid |-> ((best_position == signed'(PosNone)) == (best_distance == DistNone)))
    else $error("best index and distance disagree");

endmodule

bind hamming_best_two_matcher_top hbtm_checker u_hbtm_checker (
  .clk             (clk),
  .rst             (rst),
  .match_valid     (match_valid),
  .match_stall     (match_stall),
  .best_distance   (best_distance),
  .best_position   (best_position),
  .second_distance (second_distance)
);
